### rtl/core/pba_pkg.sv
`timescale 1ns / 1ps
package pba_pkg;
    localparam int ENTRIES = 16;
    localparam int EW = $clog2(ENTRIES);
    localparam int MAP_BLOCKS = 16;
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        MODE_FIRST = 3'd0, MODE_SEQ = 3'd1, MODE_FREE = 3'd2,
        MODE_LOOKUP = 3'd3, MODE_RESERVE = 3'd4, MODE_RESET = 3'd5,
        MODE_NOP6 = 3'd6, MODE_NOP7 = 3'd7
    } t_mode;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_ENTRY = 3'd1;
    localparam logic [2:0] ST_DUP = 3'd2;
    localparam logic [2:0] ST_NO_SPACE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic CFG_EXT_MAIN = 1'b0;
    localparam logic CFG_EXT_SUB = 1'b1;
    localparam logic [13:0] NORMAL_LIMIT = 14'h200;

    typedef struct packed {
        logic [2:0] mode;
        logic [15:0] res_id;
        logic [1:0] target;
        logic [8:0] block_count;
        logic extended;
        logic [15:0] reserve_mask;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [12:0] addr_main;
        logic [12:0] addr_sub;
        logic entry_active;
    } t_rsp;

    // classified request passed from front to back
    typedef struct packed {
        t_req req;
        logic is_alloc;
        logic is_find;
        logic is_reserve;
        logic is_clear;
    } t_cmd;

    function automatic logic [15:0] run_bits(input logic [12:0] addr, input logic [8:0] cnt);
        logic [15:0] m;
        logic [9:0] idx;
        m = '0;
        for (int k = 0; k < MAP_BLOCKS; k++) begin
            idx = 10'(addr[12:5]) + 10'(k);
            if (9'(k) < cnt && idx < 10'(MAP_BLOCKS)) m[idx[3:0]] = 1'b1;
        end
        return m;
    endfunction
endpackage

### rtl/core/pba_front.sv
`timescale 1ns / 1ps
module pba_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  pba_pkg::t_req i_req,
    output logic o_q_valid,
    input  logic i_q_pop,
    output pba_pkg::t_cmd o_q_cmd
);
    pba_pkg::t_cmd r_q [pba_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    pba_pkg::t_cmd n_cmd;
    logic push;

    always_comb begin
        n_cmd.req = i_req;
        n_cmd.is_alloc = (i_req.mode == pba_pkg::MODE_FIRST) || (i_req.mode == pba_pkg::MODE_SEQ);
        n_cmd.is_find = (i_req.mode == pba_pkg::MODE_FREE) || (i_req.mode == pba_pkg::MODE_LOOKUP);
        n_cmd.is_reserve = i_req.mode == pba_pkg::MODE_RESERVE;
        n_cmd.is_clear = i_req.mode == pba_pkg::MODE_RESET;
    end

    assign o_ready = r_cnt != 2'(pba_pkg::QDEPTH);
    assign push = i_valid && o_ready;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

### rtl/core/pba_back.sv
`timescale 1ns / 1ps
module pba_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    output logic o_q_pop,
    input  pba_pkg::t_cmd i_q_cmd,
    input  logic i_cfg_valid,
    input  logic i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output logic o_valid,
    input  logic i_ready,
    output pba_pkg::t_rsp o_rsp
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIT, S_DO, S_OUT} t_state;
    t_state r_state;
    pba_pkg::t_cmd r_cmd;
    logic [pba_pkg::EW-1:0] r_i;
    logic r_free_found, r_id_found;
    logic [pba_pkg::EW-1:0] r_free_e, r_id_e;
    logic [4:0] r_pos;
    logic r_fm, r_fs;
    logic [3:0] r_om, r_os;
    logic [15:0] r_map_m, r_map_s;
    logic [13:0] r_bp [4];
    logic [13:0] r_ext_m, r_ext_s;
    logic r_ev [pba_pkg::ENTRIES];
    logic [15:0] r_eid [pba_pkg::ENTRIES];
    logic [1:0] r_etg [pba_pkg::ENTRIES];
    logic [8:0] r_ebk [pba_pkg::ENTRIES];
    logic [12:0] r_eam [pba_pkg::ENTRIES];
    logic [12:0] r_eas [pba_pkg::ENTRIES];
    pba_pkg::t_rsp r_rsp;

    logic [15:0] need, win_m, win_s;
    logic [4:0] fit_end;
    logic [1:0] tg;
    logic [1:0] pm, ps;
    logic [13:0] lm, ls;
    logic [14:0] bytes, sum_m, sum_s;
    logic bad_m, bad_s, fit_fail;
    logic [12:0] am, as;

    always_comb begin
        tg = r_cmd.req.target;
        need = (r_cmd.req.block_count >= 9'd16) ? 16'hFFFF
             : 16'((17'd1 << r_cmd.req.block_count[4:0]) - 17'd1);
        win_m = need << r_pos[3:0];
        win_s = win_m;
        fit_end = r_pos + 5'(r_cmd.req.block_count[4:0]);
        pm = r_cmd.req.extended ? 2'd2 : 2'd0;
        ps = r_cmd.req.extended ? 2'd3 : 2'd1;
        lm = r_cmd.req.extended ? r_ext_m : pba_pkg::NORMAL_LIMIT;
        ls = r_cmd.req.extended ? r_ext_s : pba_pkg::NORMAL_LIMIT;
        bytes = {1'b0, r_cmd.req.block_count, 5'd0};
        sum_m = 15'(r_bp[pm]) + bytes;
        sum_s = 15'(r_bp[ps]) + bytes;
        bad_m = tg[0] && sum_m > 15'(lm);
        bad_s = tg[1] && sum_s > 15'(ls);
        fit_fail = (tg[0] && !r_fm) || (tg[1] && !r_fs);
        am = '0;
        as = '0;
        if (r_cmd.req.mode == pba_pkg::MODE_FIRST) begin
            if (tg[0]) am = {4'd0, r_om, 5'd0};
            if (tg[1]) as = {4'd0, r_os, 5'd0};
        end else begin
            if (tg[0]) am = r_bp[pm][12:0];
            if (tg[1]) as = r_bp[ps][12:0];
        end
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_state == S_OUT;
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_map_m <= '0;
            r_map_s <= '0;
            for (int k = 0; k < 4; k++) r_bp[k] <= '0;
            r_ext_m <= '0;
            r_ext_s <= '0;
            for (int k = 0; k < pba_pkg::ENTRIES; k++) r_ev[k] <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == pba_pkg::CFG_EXT_MAIN) r_ext_m <= i_cfg_data;
                else r_ext_s <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        r_i <= '0;
                        r_free_found <= 1'b0;
                        r_id_found <= 1'b0;
                        r_pos <= '0;
                        r_fm <= 1'b0;
                        r_fs <= 1'b0;
                        r_om <= '0;
                        r_os <= '0;
                        r_state <= (i_q_cmd.is_alloc || i_q_cmd.is_find) ? S_SCAN : S_DO;
                    end
                end
                S_SCAN: begin
                    if (!r_ev[r_i] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_e <= r_i;
                    end
                    if (r_ev[r_i] && r_eid[r_i] == r_cmd.req.res_id && !r_id_found) begin
                        r_id_found <= 1'b1;
                        r_id_e <= r_i;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == pba_pkg::EW'(pba_pkg::ENTRIES - 1))
                        r_state <= (r_cmd.req.mode == pba_pkg::MODE_FIRST) ? S_FIT : S_DO;
                end
                S_FIT: begin
                    if (r_cmd.req.block_count == 9'd0) begin
                        r_fm <= 1'b1;
                        r_fs <= 1'b1;
                        r_state <= S_DO;
                    end else if (r_cmd.req.block_count > 9'd16 || fit_end > 5'd16) begin
                        r_state <= S_DO;
                    end else begin
                        if (!r_fm && (r_map_m & win_m) == 16'd0) begin
                            r_fm <= 1'b1;
                            r_om <= r_pos[3:0];
                        end
                        if (!r_fs && (r_map_s & win_s) == 16'd0) begin
                            r_fs <= 1'b1;
                            r_os <= r_pos[3:0];
                        end
                        r_pos <= r_pos + 5'd1;
                    end
                end
                S_DO: begin
                    r_rsp <= '0;
                    r_state <= S_OUT;
                    if (r_cmd.is_alloc) begin
                        if (!r_free_found) r_rsp.status <= pba_pkg::ST_NO_ENTRY;
                        else if (r_id_found) r_rsp.status <= pba_pkg::ST_DUP;
                        else if ((r_cmd.req.mode == pba_pkg::MODE_FIRST) ? fit_fail
                                 : (bad_m || bad_s)) r_rsp.status <= pba_pkg::ST_NO_SPACE;
                        else begin
                            r_rsp.addr_main <= am;
                            r_rsp.addr_sub <= as;
                            r_ev[r_free_e] <= 1'b1;
                            r_eid[r_free_e] <= r_cmd.req.res_id;
                            r_etg[r_free_e] <= tg;
                            r_ebk[r_free_e] <= r_cmd.req.block_count;
                            r_eam[r_free_e] <= am;
                            r_eas[r_free_e] <= as;
                            if (tg[0]) r_map_m <= r_map_m | pba_pkg::run_bits(am, r_cmd.req.block_count);
                            if (tg[1]) r_map_s <= r_map_s | pba_pkg::run_bits(as, r_cmd.req.block_count);
                            if (r_cmd.req.mode == pba_pkg::MODE_SEQ) begin
                                if (tg[0]) r_bp[pm] <= sum_m[13:0];
                                if (tg[1]) r_bp[ps] <= sum_s[13:0];
                            end
                        end
                    end else if (r_cmd.is_find) begin
                        if (!r_id_found) r_rsp.status <= pba_pkg::ST_NOT_FOUND;
                        else begin
                            if (r_etg[r_id_e][0]) r_rsp.addr_main <= r_eam[r_id_e];
                            if (r_etg[r_id_e][1]) r_rsp.addr_sub <= r_eas[r_id_e];
                            if (r_cmd.req.mode == pba_pkg::MODE_FREE) begin
                                if (r_etg[r_id_e][0]) r_map_m <= r_map_m
                                    & ~pba_pkg::run_bits(r_eam[r_id_e], r_ebk[r_id_e]);
                                if (r_etg[r_id_e][1]) r_map_s <= r_map_s
                                    & ~pba_pkg::run_bits(r_eas[r_id_e], r_ebk[r_id_e]);
                                r_ev[r_id_e] <= 1'b0;
                            end else r_rsp.entry_active <= 1'b1;
                        end
                    end else if (r_cmd.is_reserve) begin
                        if (tg[0]) r_map_m <= r_map_m | r_cmd.req.reserve_mask;
                        if (tg[1]) r_map_s <= r_map_s | r_cmd.req.reserve_mask;
                    end else if (r_cmd.is_clear) begin
                        r_map_m <= '0;
                        r_map_s <= '0;
                        for (int k = 0; k < 4; k++) r_bp[k] <= '0;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/palette_block_allocator.sv
`timescale 1ns / 1ps
// channel | direction | handshake
// req     | in        | i_valid / o_ready, i_req
// rsp     | out       | o_valid / i_ready, o_rsp
// cfg     | in        | i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
// alloc/free/lookup: entry table scan, plus a bitmap fit search for first-fit allocs
// reserve, reset and unused modes skip the scan and go straight to the update state
// a two-deep request queue keeps taking requests while the back end works or stalls, until it is full
// reset is synchronous, active low, and clears entries' valid bits, maps and pointers
module palette_block_allocator (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  pba_pkg::t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output pba_pkg::t_rsp o_rsp,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_index,
    input  logic [13:0] i_cfg_data
);
    logic q_valid, q_pop;
    pba_pkg::t_cmd q_cmd;
    assign o_cfg_ready = 1'b1;

    pba_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_req,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd));
    pba_back u_back (.i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_cmd(q_cmd), .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_valid, .i_ready, .o_rsp);
endmodule

### rtl/core/pba_checker.sv
`timescale 1ns / 1ps
module pba_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input pba_pkg::t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp)) else $error("rsp changed");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status <= pba_pkg::ST_NOT_FOUND) else $error("bad status");
    a_fail0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != pba_pkg::ST_OK |->
        o_rsp.addr_main == 13'd0 && o_rsp.addr_sub == 13'd0 && !o_rsp.entry_active)
        else $error("failure carries data");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind palette_block_allocator pba_checker u_chk (.i_clk, .i_rst_n, .o_valid, .i_ready, .o_rsp);

### tb/sv/tb_palette_block_allocator.sv
`timescale 1ns / 1ps
module tb_palette_block_allocator;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    pba_pkg::t_req i_req;
    pba_pkg::t_rsp o_rsp;
    logic i_cfg_valid, o_cfg_ready, i_cfg_index;
    logic [13:0] i_cfg_data;

    palette_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // allocator shadow state
    int ext_main, ext_sub;
    bit slot_used [pba_pkg::ENTRIES];
    int slot_id [pba_pkg::ENTRIES];
    int slot_tgt [pba_pkg::ENTRIES];
    int slot_cnt [pba_pkg::ENTRIES];
    int slot_am [pba_pkg::ENTRIES];
    int slot_as [pba_pkg::ENTRIES];
    int map_main, map_sub;
    int bump [4];

    pba_pkg::t_rsp rsp_pending [$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    int id_pool [24];

    pba_pkg::t_req dir_req [$];
    pba_pkg::t_rsp dir_rsp [$];
    bit dir_typed [$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int block_mask(int addr, int cnt);
        int m, idx;
        m = 0;
        for (int k = 0; k < cnt; k++) begin
            idx = addr / 32 + k;
            if (idx < pba_pkg::MAP_BLOCKS) m |= 1 << idx;
        end
        return m;
    endfunction

    function automatic int lowest_run(int map, int cnt);
        int need;
        if (cnt > pba_pkg::MAP_BLOCKS) return -1;
        if (cnt == 0) return 0;
        need = (1 << cnt) - 1;
        for (int i = 0; i + cnt <= pba_pkg::MAP_BLOCKS; i++)
            if ((map & (need << i)) == 0) return i;
        return -1;
    endfunction

    function automatic int slot_of(int id);
        for (int i = 0; i < pba_pkg::ENTRIES; i++)
            if (slot_used[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic pba_pkg::t_rsp allocate_step(pba_pkg::t_req r);
        pba_pkg::t_rsp o;
        int e, id, tgt, cnt, om, os, pm, ps, lm, ls, bytes, am, as;
        o = '0;
        id = r.res_id; tgt = r.target; cnt = r.block_count;
        am = 0; as = 0;
        if (r.mode == pba_pkg::MODE_FIRST || r.mode == pba_pkg::MODE_SEQ) begin
            e = -1;
            for (int i = pba_pkg::ENTRIES - 1; i >= 0; i--) if (!slot_used[i]) e = i;
            if (e < 0) o.status = pba_pkg::ST_NO_ENTRY;
            else if (slot_of(id) >= 0) o.status = pba_pkg::ST_DUP;
            else if (r.mode == pba_pkg::MODE_FIRST) begin
                om = tgt[0] ? lowest_run(map_main, cnt) : 0;
                os = tgt[1] ? lowest_run(map_sub, cnt) : 0;
                if (om < 0 || os < 0) o.status = pba_pkg::ST_NO_SPACE;
                else begin
                    if (tgt[0]) am = om * 32;
                    if (tgt[1]) as = os * 32;
                end
            end else begin
                pm = r.extended ? 2 : 0;
                ps = r.extended ? 3 : 1;
                lm = r.extended ? ext_main : int'(pba_pkg::NORMAL_LIMIT);
                ls = r.extended ? ext_sub : int'(pba_pkg::NORMAL_LIMIT);
                bytes = cnt * 32;
                if ((tgt[0] && bump[pm] + bytes > lm) || (tgt[1] && bump[ps] + bytes > ls))
                    o.status = pba_pkg::ST_NO_SPACE;
                else begin
                    if (tgt[0]) begin
                        am = bump[pm] & 'h1fff;
                        bump[pm] = (bump[pm] + bytes) & 'h3fff;
                    end
                    if (tgt[1]) begin
                        as = bump[ps] & 'h1fff;
                        bump[ps] = (bump[ps] + bytes) & 'h3fff;
                    end
                end
            end
            if (e >= 0 && o.status == pba_pkg::ST_OK) begin
                slot_used[e] = 1; slot_id[e] = id; slot_tgt[e] = tgt;
                slot_cnt[e] = cnt; slot_am[e] = am; slot_as[e] = as;
                if (tgt[0]) map_main |= block_mask(am, cnt);
                if (tgt[1]) map_sub |= block_mask(as, cnt);
            end
        end else if (r.mode == pba_pkg::MODE_FREE || r.mode == pba_pkg::MODE_LOOKUP) begin
            e = slot_of(id);
            if (e < 0) o.status = pba_pkg::ST_NOT_FOUND;
            else begin
                if (slot_tgt[e] & 1) am = slot_am[e];
                if (slot_tgt[e] & 2) as = slot_as[e];
                if (r.mode == pba_pkg::MODE_FREE) begin
                    if (slot_tgt[e] & 1) map_main &= ~block_mask(am, slot_cnt[e]) & 'hffff;
                    if (slot_tgt[e] & 2) map_sub &= ~block_mask(as, slot_cnt[e]) & 'hffff;
                    slot_used[e] = 0;
                end else o.entry_active = 1'b1;
            end
        end else if (r.mode == pba_pkg::MODE_RESERVE) begin
            if (tgt[0]) map_main |= int'(r.reserve_mask);
            if (tgt[1]) map_sub |= int'(r.reserve_mask);
        end else if (r.mode == pba_pkg::MODE_RESET) begin
            for (int i = 0; i < 4; i++) bump[i] = 0;
            map_main = 0;
            map_sub = 0;
        end
        o.addr_main = am[12:0];
        o.addr_sub = as[12:0];
        return o;
    endfunction

    function automatic pba_pkg::t_req mk(pba_pkg::t_mode m, int id, int tgt, int cnt, bit ext,
                                         int mask);
        pba_pkg::t_req r;
        r.mode = m; r.res_id = 16'(id); r.target = 2'(tgt); r.block_count = 9'(cnt);
        r.extended = ext; r.reserve_mask = 16'(mask);
        return r;
    endfunction

    task automatic row(pba_pkg::t_req r, bit typed, logic [2:0] st, int am, int as, bit act);
        pba_pkg::t_rsp x;
        x.status = st; x.addr_main = 13'(am); x.addr_sub = 13'(as); x.entry_active = act;
        dir_req.push_back(r); dir_rsp.push_back(x); dir_typed.push_back(typed);
    endtask

    task automatic send_request(pba_pkg::t_req r, bit typed, pba_pkg::t_rsp typed_rsp);
        pba_pkg::t_rsp p;
        int gap;
        if (!quiet && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        p = allocate_step(r);
        rsp_pending.push_back(typed ? typed_rsp : p);
    endtask

    task automatic write_ext(bit idx, int val);
        i_valid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 14'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == pba_pkg::CFG_EXT_MAIN) ext_main = val; else ext_sub = val;
    endtask

    function automatic pba_pkg::t_req random_request();
        pba_pkg::t_req r;
        int pick;
        r = '0;
        r.res_id = 16'(($urandom_range(99) < 90) ? id_pool[$urandom_range(23)] : $urandom);
        r.target = 2'($urandom);
        r.extended = 1'($urandom);
        r.reserve_mask = 16'(($urandom_range(9) == 0) ? $urandom : (1 << $urandom_range(15)));
        r.block_count = 9'(($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 6));
        pick = $urandom_range(99);
        if (pick < 38) r.mode = pba_pkg::MODE_FIRST;
        else if (pick < 58) r.mode = pba_pkg::MODE_SEQ;
        else if (pick < 78) r.mode = pba_pkg::MODE_FREE;
        else if (pick < 90) r.mode = pba_pkg::MODE_LOOKUP;
        else if (pick < 94) r.mode = pba_pkg::MODE_RESERVE;
        else if (pick < 97) r.mode = pba_pkg::MODE_RESET;
        else r.mode = pick[0] ? pba_pkg::MODE_NOP6 : pba_pkg::MODE_NOP7;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** palette_block_allocator: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= quiet || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        pba_pkg::t_rsp x;
        if (i_rst_n && o_valid && i_ready) begin
            if (rsp_pending.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                errors++;
            end else begin
                x = rsp_pending.pop_front();
                if (x.status !== o_rsp.status) begin
                    $display("%0t: status exp %0d got %0d", $time, x.status, o_rsp.status);
                    errors++;
                end
                if (x.addr_main !== o_rsp.addr_main) begin
                    $display("%0t: addr_main exp %h got %h", $time, x.addr_main,
                             o_rsp.addr_main);
                    errors++;
                end
                if (x.addr_sub !== o_rsp.addr_sub) begin
                    $display("%0t: addr_sub exp %h got %h", $time, x.addr_sub, o_rsp.addr_sub);
                    errors++;
                end
                if (x.entry_active !== o_rsp.entry_active) begin
                    $display("%0t: entry_active exp %b got %b", $time, x.entry_active,
                             o_rsp.entry_active);
                    errors++;
                end
            end
        end
    end

    initial begin
        int ext_settings [5][2];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        ext_main = 0; ext_sub = 0; map_main = 0; map_sub = 0;
        for (int i = 0; i < 4; i++) bump[i] = 0;
        for (int i = 0; i < pba_pkg::ENTRIES; i++) slot_used[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at reset settings
        row(mk(pba_pkg::MODE_LOOKUP, 5, 3, 1, 0, 0), 1, pba_pkg::ST_NOT_FOUND, 0, 0, 0);
        row(mk(pba_pkg::MODE_FREE, 'hffff, 3, 1, 0, 0), 1, pba_pkg::ST_NOT_FOUND, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 1, 3, 16, 0, 0), 1, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 2, 1, 1, 0, 0), 1, pba_pkg::ST_NO_SPACE, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 1, 2, 1, 0, 0), 1, pba_pkg::ST_DUP, 0, 0, 0);
        row(mk(pba_pkg::MODE_LOOKUP, 1, 0, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FREE, 1, 0, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 3, 0, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 4, 3, 17, 0, 0), 1, pba_pkg::ST_NO_SPACE, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 5, 3, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 0, 1, 3, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_SEQ, 6, 3, 16, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_SEQ, 7, 1, 1, 1, 0), 1, pba_pkg::ST_NO_SPACE, 0, 0, 0);
        row(mk(pba_pkg::MODE_SEQ, 8, 2, 256, 0, 0), 1, pba_pkg::ST_NO_SPACE, 0, 0, 0);
        row(mk(pba_pkg::MODE_SEQ, 9, 2, 'h1ff, 1, 0), 1, pba_pkg::ST_NO_SPACE, 0, 0, 0);
        row(mk(pba_pkg::MODE_RESERVE, 10, 3, 0, 0, 'hffff), 1, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FIRST, 11, 2, 1, 0, 0), 1, pba_pkg::ST_NO_SPACE, 0, 0, 0);
        row(mk(pba_pkg::MODE_RESERVE, 12, 1, 0, 0, 0), 1, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_RESET, 'hffff, 3, 'h1ff, 1, 'hffff), 1, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_NOP6, 6, 3, 4, 1, 'hffff), 1, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_NOP7, 6, 3, 4, 1, 'hffff), 1, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_LOOKUP, 6, 0, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FREE, 6, 0, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        row(mk(pba_pkg::MODE_FREE, 5, 0, 0, 0, 0), 0, pba_pkg::ST_OK, 0, 0, 0);
        for (int i = 0; i < dir_req.size(); i++)
            send_request(dir_req[i], dir_typed[i], dir_rsp[i]);

        ext_settings = '{'{8192, 8192}, '{0, 8192}, '{8192, 0}, '{0, 0}, '{0, 0}};
        ext_settings[4][0] = $urandom_range(8192);
        ext_settings[4][1] = $urandom_range(8192);
        for (int ph = 0; ph < 5; ph++) begin
            write_ext(pba_pkg::CFG_EXT_MAIN, ext_settings[ph][0]);
            write_ext(pba_pkg::CFG_EXT_SUB, ext_settings[ph][1]);
            for (int i = 0; i < 24; i++) id_pool[i] = $urandom;
            quiet = (ph == 1);
            for (int n = 0; n < 286; n++)
                send_request(random_request(), 0, '0);
            quiet = 0;
        end
        i_valid <= 1'b0;

        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("** palette_block_allocator: PASSED **");
        else $display("** palette_block_allocator: FAILED **");
        $finish;
    end
endmodule
